[design/htt_pkg.sv]
// ----------------------------------------------------------------------------
// htt_pkg
// Shared types, token codes and the tag pattern table of the tag tokenizer.
// ----------------------------------------------------------------------------
package htt_pkg;

  localparam int NUM_TAGS = 22;
  localparam int MAX_RES  = 3;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_LT = 8'h3C;

  localparam logic [4:0] KIND_TEXT     = 5'd0;
  localparam logic [4:0] KIND_TEXT_END = 5'd23;
  localparam logic [4:0] KIND_UNKNOWN  = 5'd24;

  localparam logic [NUM_TAGS-1:0] ALL_TAGS = '1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TEXT,
    MODE_TAG
  } mode_t;

  typedef struct packed {
    logic [1:0]                count;
    logic [MAX_RES-1:0][4:0]   kind;
    logic [7:0]                text;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [3:0] tag_len(input logic [4:0] idx);
    logic [3:0] len;
    case (idx)
      5'd0, 5'd4, 5'd8: len = 4'd6;
      5'd1, 5'd5, 5'd6, 5'd9: len = 4'd7;
      5'd2: len = 4'd3;
      5'd3, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20: len = 4'd4;
      5'd7: len = 4'd8;
      default: len = 4'd5;
    endcase
    return len;
  endfunction

  function automatic logic [63:0] tag_text(input logic [4:0] idx);
    logic [63:0] txt;
    case (idx)
      5'd0:  txt = 64'("<html>");
      5'd1:  txt = 64'("</html>");
      5'd2:  txt = 64'("<p>");
      5'd3:  txt = 64'("</p>");
      5'd4:  txt = 64'("<body>");
      5'd5:  txt = 64'("</body>");
      5'd6:  txt = 64'("<title>");
      5'd7:  txt = 64'("</title>");
      5'd8:  txt = 64'("<head>");
      5'd9:  txt = 64'("</head>");
      5'd10: txt = 64'("<h1>");
      5'd11: txt = 64'("</h1>");
      5'd12: txt = 64'("<h2>");
      5'd13: txt = 64'("</h2>");
      5'd14: txt = 64'("<h3>");
      5'd15: txt = 64'("</h3>");
      5'd16: txt = 64'("<h4>");
      5'd17: txt = 64'("</h4>");
      5'd18: txt = 64'("<h5>");
      5'd19: txt = 64'("</h5>");
      5'd20: txt = 64'("<h6>");
      5'd21: txt = 64'("</h6>");
      default: txt = '0;
    endcase
    return txt;
  endfunction

  // Character at position pos of tag idx; caller guarantees pos < tag_len(idx).
  function automatic logic [7:0] tag_char(input logic [4:0] idx, input logic [3:0] pos);
    logic [3:0]  off;
    logic [63:0] txt;
    off = tag_len(idx) - 4'd1 - pos;
    txt = tag_text(idx) >> {off[2:0], 3'b000};
    return txt[7:0];
  endfunction

endpackage

[design/html_tag_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// html_tag_tokenizer_core
// Markup tag tokenizer: one source byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// Path: a byte's bundle is registered in the queue, then in htt_back's cur_r.
// Throughput: one byte per cycle while each byte gives at most one token and
//   out_stall is low; a byte giving n tokens holds the port for n transfers,
//   and the bundle queue (QUEUE_DEPTH entries) absorbs the difference.
// Reset: synchronous, active low; scan state, queue and output go empty/idle.
// ----------------------------------------------------------------------------
module html_tag_tokenizer_core
  import htt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_text_byte,
  output logic       out_last_result
);

  qstat_t  q_stat;
  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t pop_data;

  htt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .q_stat          (q_stat),
    .push            (push),
    .push_data       (push_data)
  );

  htt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  htt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop             (pop),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_text_byte   (out_text_byte),
    .out_last_result (out_last_result)
  );

endmodule

[design/htt_front.sv]
// ----------------------------------------------------------------------------
// htt_front
// Accepts source bytes, tracks scan mode and tag candidates, and packs the
// tokens caused by each byte into one bundle.
// ----------------------------------------------------------------------------
module htt_front
  import htt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  input  qstat_t     q_stat,
  output logic       push,
  output bundle_t    push_data
);

  mode_t               mode_r, mode_nxt;
  logic [NUM_TAGS-1:0] cand_r, cand_nxt;
  logic [3:0]          pos_r, pos_nxt;

  logic [NUM_TAGS-1:0] match;
  logic                done;
  logic [4:0]          done_kind;
  logic                is_ws;
  logic                is_lt;
  logic [1:0]          cnt;
  logic [MAX_RES-1:0][4:0] kinds;
  logic                accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign is_ws    = (in_byte == CHAR_LF) || (in_byte == CHAR_TAB) ||
                    (in_byte == CHAR_CR) || (in_byte == CHAR_SP);
  assign is_lt    = (in_byte == CHAR_LT);

  always_comb begin
    match     = '0;
    done      = 1'b0;
    done_kind = KIND_TEXT;
    for (int i = 0; i < NUM_TAGS; i++) begin
      if (cand_r[i] && (pos_r < tag_len(5'(i))) && (tag_char(5'(i), pos_r) == in_byte)) begin
        match[i] = 1'b1;
      end
    end
    for (int i = NUM_TAGS - 1; i >= 0; i--) begin
      if (match[i] && (tag_len(5'(i)) == pos_r + 4'd1)) begin
        done      = 1'b1;
        done_kind = 5'(i + 1);
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cand_nxt = cand_r;
    pos_nxt  = pos_r;
    cnt      = 2'd0;
    kinds    = '0;
    unique case (mode_r)
      MODE_TEXT: begin
        if (is_lt) begin
          kinds[cnt] = KIND_TEXT_END;
          cnt        = cnt + 2'd1;
          mode_nxt   = MODE_TAG;
          cand_nxt   = ALL_TAGS;
          pos_nxt    = 4'd1;
        end else begin
          kinds[cnt] = KIND_TEXT;
          cnt        = cnt + 2'd1;
        end
      end
      MODE_TAG: begin
        if (match == '0) begin
          kinds[cnt] = KIND_UNKNOWN;
          cnt        = cnt + 2'd1;
          if (is_ws) begin
            mode_nxt = MODE_IDLE;
            cand_nxt = '0;
            pos_nxt  = 4'd0;
          end else if (is_lt) begin
            mode_nxt = MODE_TAG;
            cand_nxt = ALL_TAGS;
            pos_nxt  = 4'd1;
          end else begin
            mode_nxt   = MODE_TEXT;
            cand_nxt   = '0;
            pos_nxt    = 4'd0;
            kinds[cnt] = KIND_TEXT;
            cnt        = cnt + 2'd1;
          end
        end else if (done) begin
          kinds[cnt] = done_kind;
          cnt        = cnt + 2'd1;
          mode_nxt   = MODE_IDLE;
          cand_nxt   = '0;
          pos_nxt    = 4'd0;
        end else begin
          cand_nxt = match;
          pos_nxt  = pos_r + 4'd1;
        end
      end
      default: begin
        if (is_ws) begin
          mode_nxt = MODE_IDLE;
        end else if (is_lt) begin
          mode_nxt = MODE_TAG;
          cand_nxt = ALL_TAGS;
          pos_nxt  = 4'd1;
        end else begin
          mode_nxt   = MODE_TEXT;
          kinds[cnt] = KIND_TEXT;
          cnt        = cnt + 2'd1;
        end
      end
    endcase
    if (in_end_of_input) begin
      if (mode_nxt == MODE_TEXT) begin
        kinds[cnt] = KIND_TEXT_END;
        cnt        = cnt + 2'd1;
      end else if (mode_nxt == MODE_TAG) begin
        kinds[cnt] = KIND_UNKNOWN;
        cnt        = cnt + 2'd1;
      end
      mode_nxt = MODE_IDLE;
      cand_nxt = '0;
      pos_nxt  = 4'd0;
    end
  end

  assign push            = accept && (cnt != 2'd0);
  assign push_data.count = cnt;
  assign push_data.kind  = kinds;
  assign push_data.text  = in_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cand_r <= '0;
      pos_r  <= 4'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cand_r <= cand_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

[design/htt_queue.sv]
// ----------------------------------------------------------------------------
// htt_queue
// Short first-in first-out queue of token bundles between front and back.
// ----------------------------------------------------------------------------
module htt_queue
  import htt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t pop_data,
  output qstat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/htt_back.sv]
// ----------------------------------------------------------------------------
// htt_back
// Takes bundles from the queue and issues their tokens one transfer at a time.
// ----------------------------------------------------------------------------
module htt_back
  import htt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qstat_t     q_stat,
  output logic       pop,
  input  bundle_t    pop_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_text_byte,
  output logic       out_last_result
);

  bundle_t    cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       take;
  logic       last;
  logic       need_load;

  assign take      = busy_r && !out_stall;
  assign last      = (idx_r == cur_r.count - 2'd1);
  assign need_load = !busy_r || (take && last);
  assign pop       = need_load && !q_stat.empty;

  always_comb begin
    cur_nxt  = pop ? pop_data : cur_r;
    busy_nxt = need_load ? !q_stat.empty : busy_r;
    if (need_load) begin
      idx_nxt = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  assign out_valid       = busy_r;
  assign out_token_kind  = cur_r.kind[idx_r];
  assign out_text_byte   = (cur_r.kind[idx_r] == KIND_TEXT) ? cur_r.text : 8'h00;
  assign out_last_result = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

[dv/tb_html_tag_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_html_tag_tokenizer_core
// Self-checking bench for the markup tag tokenizer. It streams tags, text
// runs, whitespace, broken tags and raw noise into the core under random
// stalls on both channels. Each token is checked against a scanner model
// kept in a scoreboard.
// ----------------------------------------------------------------------------

module tb_html_tag_tokenizer_core
  import htt_pkg::*;
;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text;
    logic       last;
  } token_t;

  class token_scoreboard;
    string               tag_pat[NUM_TAGS];
    mode_t               scan_mode;
    logic [NUM_TAGS-1:0] cands;
    logic [3:0]          tag_pos;
    token_t              byte_tokens[$];
    token_t              expected_tokens[$];
    int                  fail_count;
    int                  checked;
    int                  tags_seen;
    int                  unknown_seen;
    int                  text_ends;

    function new();
      tag_pat = '{"<html>", "</html>", "<p>", "</p>", "<body>", "</body>",
                  "<title>", "</title>", "<head>", "</head>", "<h1>", "</h1>",
                  "<h2>", "</h2>", "<h3>", "</h3>", "<h4>", "</h4>",
                  "<h5>", "</h5>", "<h6>", "</h6>"};
      clear_scan();
      fail_count   = 0;
      checked      = 0;
      tags_seen    = 0;
      unknown_seen = 0;
      text_ends    = 0;
    endfunction

    function void clear_scan();
      scan_mode = MODE_IDLE;
      cands     = '0;
      tag_pos   = '0;
    endfunction

    function void open_tag();
      scan_mode = MODE_TAG;
      cands     = ALL_TAGS;
      tag_pos   = 4'd1;
    endfunction

    function void push_token(logic [4:0] kind, logic [7:0] b);
      token_t t;
      if (byte_tokens.size() >= MAX_RES) return;
      t.kind = kind;
      t.text = (kind == KIND_TEXT) ? b : 8'h00;
      t.last = 1'b0;
      byte_tokens.insert(byte_tokens.size(), t);
    endfunction

    function void idle_byte(logic [7:0] b);
      if (b == CHAR_LF || b == CHAR_TAB || b == CHAR_CR || b == CHAR_SP) begin
        scan_mode = MODE_IDLE;
      end else if (b == CHAR_LT) begin
        open_tag();
      end else begin
        scan_mode = MODE_TEXT;
        push_token(KIND_TEXT, b);
      end
    endfunction

    function void tag_byte(logic [7:0] b);
      logic [NUM_TAGS-1:0] hits;
      logic [7:0]          c;
      bit                  done;
      hits = '0;
      done = 1'b0;
      for (int i = 0; i < NUM_TAGS; i++) begin
        if (cands[i] && tag_pos < tag_pat[i].len()) begin
          c = tag_pat[i][tag_pos];
          if (c == b) hits[i] = 1'b1;
        end
      end
      if (hits == '0) begin
        // drop the partial tag, then rescan this byte from idle
        push_token(KIND_UNKNOWN, 8'h00);
        clear_scan();
        idle_byte(b);
      end else begin
        for (int i = 0; i < NUM_TAGS; i++) begin
          if (!done && hits[i] && tag_pat[i].len() == tag_pos + 1) begin
            push_token(5'(i + 1), 8'h00);
            clear_scan();
            done = 1'b1;
          end
        end
        if (!done) begin
          cands   = hits;
          tag_pos = tag_pos + 4'd1;
        end
      end
    endfunction

    function void note_input(logic [7:0] b, logic eoi);
      token_t t;
      byte_tokens.delete();
      case (scan_mode)
        MODE_TEXT: begin
          if (b == CHAR_LT) begin
            push_token(KIND_TEXT_END, 8'h00);
            open_tag();
          end else begin
            push_token(KIND_TEXT, b);
          end
        end
        MODE_TAG: tag_byte(b);
        default: idle_byte(b);
      endcase
      if (eoi) begin
        if (scan_mode == MODE_TEXT) push_token(KIND_TEXT_END, 8'h00);
        else if (scan_mode == MODE_TAG) push_token(KIND_UNKNOWN, 8'h00);
        clear_scan();
      end
      if (byte_tokens.size() > 0) begin
        t = byte_tokens.pop_back();
        t.last = 1'b1;
        byte_tokens.insert(byte_tokens.size(), t);
      end
      foreach (byte_tokens[i]) expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
    endfunction

    function int outstanding();
      return expected_tokens.size();
    endfunction

    function bit count_failure();
      fail_count++;
      return fail_count <= 10;
    endfunction

    function void check_result(logic [4:0] kind, logic [7:0] text, logic last);
      token_t want;
      if (expected_tokens.size() == 0) begin
        if (count_failure())
          $display("ERROR: token with none pending: kind %0d text %02h last %0b",
                   kind, text, last);
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (want.kind == KIND_UNKNOWN) unknown_seen++;
      else if (want.kind == KIND_TEXT_END) text_ends++;
      else if (want.kind != KIND_TEXT) tags_seen++;
      if (kind !== want.kind || text !== want.text || last !== want.last) begin
        if (count_failure())
          $display({"ERROR: token %0d: expected kind %0d text %02h last %0b,",
                    " got kind %0d text %02h last %0b"},
                   checked, want.kind, want.text, want.last, kind, text, last);
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_PHASE = 40;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic [7:0] in_byte         = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_stall       = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [4:0] out_token_kind;
  logic [7:0] out_text_byte;
  logic       out_last_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  int bytes_sent    = 0;

  token_scoreboard sb = new();

  html_tag_tokenizer_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_text_byte   (out_text_byte),
    .out_last_result (out_last_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_token_kind, out_text_byte, out_last_result);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    sb.note_input(b, eoi);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eoi_last && (i == s.len() - 1));
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random(input int items);
    logic [7:0] seg[$];
    logic [7:0] c;
    int         counted;
    int         sel;
    int         idx;
    int         n;
    bit         ws_only;
    counted = 0;
    while (counted < items) begin
      seg.delete();
      ws_only = 1'b0;
      sel = $urandom_range(99);
      if (sel < 50) begin
        idx = $urandom_range(NUM_TAGS - 1);
        for (int i = 0; i < sb.tag_pat[idx].len(); i++)
          seg.insert(seg.size(), sb.tag_pat[idx][i]);
      end else if (sel < 68) begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
          c = 8'($urandom_range(255));
          if (c == CHAR_LT) c = "a";
          if ($urandom_range(3) == 0) c = CHAR_SP;
          seg.insert(seg.size(), c);
        end
      end else if (sel < 76) begin
        ws_only = 1'b1;
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(3))
            0: c = CHAR_LF;
            1: c = CHAR_TAB;
            2: c = CHAR_CR;
            default: c = CHAR_SP;
          endcase
          seg.insert(seg.size(), c);
        end
      end else if (sel < 90) begin
        // tag prefix cut short by an arbitrary byte
        idx = $urandom_range(NUM_TAGS - 1);
        n = $urandom_range(sb.tag_pat[idx].len() - 1, 1);
        for (int i = 0; i < n; i++) seg.insert(seg.size(), sb.tag_pat[idx][i]);
        seg.insert(seg.size(), 8'($urandom_range(255)));
      end else begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) seg.insert(seg.size(), 8'($urandom_range(255)));
      end
      foreach (seg[i]) send_byte(seg[i], $urandom_range(24) == 0);
      if (!ws_only) counted += seg.size();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 70;
    send_string("<p>", 1'b0);
    send_string(" \t\r\n", 1'b0);
    send_string("a b<", 1'b0);
    send_string("/p>", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_SP, 1'b1);
    send_string("<h", 1'b1);
    send_string("<x", 1'b0);
    send_string("<<h6>", 1'b0);
    send_byte(">", 1'b1);
    hold_until_drained();

    run_random(ITEMS_PER_PHASE);
    hold_until_drained();

    send_idle_pct = 70;
    recv_idle_pct = 13;
    run_random(ITEMS_PER_PHASE);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    hold_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d bytes in, %0d tokens checked (%0d tags, %0d unknown, %0d text ends)",
             bytes_sent, sb.checked, sb.tags_seen, sb.unknown_seen, sb.text_ends);
    $display("Stall mixes sender/receiver: 13/70, 70/13, 0/0; %0d mismatches",
             sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
design/htt_pkg.sv
design/htt_front.sv
design/htt_queue.sv
design/htt_back.sv
design/html_tag_tokenizer_core.sv
dv/tb_html_tag_tokenizer_core.sv
